// File: hdl/trie_pkg.sv
// ----------------------------------------------------------------------------
// trie_pkg
// Shared types and constants for the three-register instruction execute block.
// ----------------------------------------------------------------------------
package trie_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 4;
    localparam int unsigned RIDX_W = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [RIDX_W-1:0] t_ridx;

    // request kinds
    localparam t_kind K_NONE   = 4'd0;
    localparam t_kind K_LOAD   = 4'd1;
    localparam t_kind K_STORE  = 4'd2;
    localparam t_kind K_MAP    = 4'd3;
    localparam t_kind K_UNMAP  = 4'd4;
    localparam t_kind K_OUT    = 4'd5;
    localparam t_kind K_IN     = 4'd6;
    localparam t_kind K_LOADP  = 4'd7;
    localparam t_kind K_HALT   = 4'd8;
    localparam t_kind K_DIVERR = 4'd9;

    // opcodes
    localparam logic [3:0] OP_CMOV  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_NAND  = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_MAP   = 4'd8;
    localparam logic [3:0] OP_UNMAP = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;
    localparam logic [3:0] OP_IN    = 4'd11;
    localparam logic [3:0] OP_LOADP = 4'd12;
    localparam logic [3:0] OP_IMM   = 4'd13;

    // controller -> datapath
    typedef struct packed {
        logic  latch;     // capture input fields, read registers
        logic  exec;      // write result, set output fields
        logic  div_start; // load the divider
        logic  div_step;  // one restoring step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_div;     // latched item is an executable divide
    } t_sts;

endpackage

// File: hdl/trie_datapath.sv
// ----------------------------------------------------------------------------
// trie_datapath
// Register file, architectural state, radix-2 divider and result registers.
// ----------------------------------------------------------------------------
module trie_datapath #(
    parameter int unsigned REG_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  trie_pkg::t_cmd  i_cmd,
    output trie_pkg::t_sts  o_sts,
    input  logic            i_op,
    input  logic [31:0]     i_instr_word,
    input  logic [31:0]     i_resp_data,
    input  logic            i_resp_eof,
    output logic [3:0]      o_req_kind,
    output logic [31:0]     o_req_a,
    output logic [31:0]     o_req_b,
    output logic [31:0]     o_req_c,
    output logic [31:0]     o_next_pc,
    output logic            o_waiting
);
    import trie_pkg::*;

    localparam int unsigned IDX_W = $clog2(REG_COUNT);

    t_word              r_regs [REG_COUNT];
    t_word              r_pc;
    logic [IDX_W-1:0]   r_pdest;
    logic               r_pend;
    logic               r_halt;

    // latched item
    logic               r_op;
    t_word              r_w;
    t_word              r_rdata;
    logic               r_eof;
    t_word              r_va, r_vb, r_vc;

    // divider
    t_word              r_q, r_rem;

    t_kind              n_kind;
    t_word              n_qa, n_qb, n_qc;
    t_word              n_pc;
    logic               n_pend;

    logic [3:0]         opc;
    logic [IDX_W-1:0]   ia, ib, ic, iimm;
    logic [WORD_W:0]    trial;

    assign opc  = r_w[31:28];
    assign ia   = IDX_W'(r_w[8:6]);
    assign ib   = IDX_W'(r_w[5:3]);
    assign ic   = IDX_W'(r_w[2:0]);
    assign iimm = IDX_W'(r_w[27:25]);

    assign o_sts.is_div = !r_halt && !r_op && !r_pend && opc == OP_DIV && r_vc != '0;

    assign trial = {r_rem, r_q[WORD_W-1]} - {1'b0, r_vc};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_w     <= i_instr_word;
            r_rdata <= i_resp_data;
            r_eof   <= i_resp_eof;
            r_va    <= r_regs[IDX_W'(i_instr_word[8:6])];
            r_vb    <= r_regs[IDX_W'(i_instr_word[5:3])];
            r_vc    <= r_regs[IDX_W'(i_instr_word[2:0])];
        end
        if (i_cmd.div_start) begin
            r_q   <= r_vb;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[WORD_W]) begin
                r_rem <= trial[WORD_W-1:0];
                r_q   <= {r_q[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WORD_W-2:0], r_q[WORD_W-1]};
                r_q   <= {r_q[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_kind = K_NONE;
        n_qa   = '0;
        n_qb   = '0;
        n_qc   = '0;
        n_pc   = r_pc;
        n_pend = r_pend;
        if (r_halt) begin
            n_kind = K_HALT;
        end else if (r_op) begin
            n_pend = 1'b0;
        end else if (!r_pend) begin
            n_pc = r_pc + 1'b1;
            case (opc)
                OP_LOAD: begin
                    n_kind = K_LOAD; n_qa = r_vb; n_qb = r_vc; n_pend = 1'b1;
                end
                OP_STORE: begin
                    n_kind = K_STORE; n_qa = r_va; n_qb = r_vb; n_qc = r_vc;
                end
                OP_DIV:   if (r_vc == '0) n_kind = K_DIVERR;
                OP_HALT:  n_kind = K_HALT;
                OP_MAP: begin
                    n_kind = K_MAP; n_qa = r_vc; n_pend = 1'b1;
                end
                OP_UNMAP: begin
                    n_kind = K_UNMAP; n_qa = r_vc;
                end
                OP_OUT: begin
                    n_kind = K_OUT; n_qa = {24'd0, r_vc[7:0]};
                end
                OP_IN: begin
                    n_kind = K_IN; n_pend = 1'b1;
                end
                OP_LOADP: begin
                    if (r_vb != '0) begin
                        n_kind = K_LOADP; n_qa = r_vb;
                    end
                    n_pc = r_vc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_regs[i] <= '0;
            r_pc       <= '0;
            r_pdest    <= '0;
            r_pend     <= 1'b0;
            r_halt     <= 1'b0;
            o_req_kind <= K_NONE;
            o_waiting  <= 1'b0;
        end else if (i_cmd.exec) begin
            o_req_kind <= n_kind;
            o_req_a    <= n_qa;
            o_req_b    <= n_qb;
            o_req_c    <= n_qc;
            o_next_pc  <= n_pc;
            o_waiting  <= n_pend;
            r_pc       <= n_pc;
            r_pend     <= n_pend;
            if (!r_halt) begin
                if (r_op) begin
                    if (r_pend) r_regs[r_pdest] <= r_eof ? '1 : r_rdata;
                end else if (!r_pend) begin
                    case (opc)
                        OP_CMOV:  if (r_vc != '0) r_regs[ia] <= r_vb;
                        OP_LOAD:  r_pdest <= ia;
                        OP_ADD:   r_regs[ia] <= r_vb + r_vc;
                        OP_MUL:   r_regs[ia] <= r_vb * r_vc;
                        OP_DIV:   if (r_vc != '0) r_regs[ia] <= r_q;
                        OP_NAND:  r_regs[ia] <= ~(r_vb & r_vc);
                        OP_HALT:  r_halt <= 1'b1;
                        OP_MAP:   r_pdest <= ib;
                        OP_IN:    r_pdest <= ic;
                        OP_IMM:   r_regs[iimm] <= {7'd0, r_w[24:0]};
                        default: ;
                    endcase
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) |-> r_halt)
        else $error("halt flag cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_halt |=> o_req_kind == K_HALT)
        else $error("halted result not halt");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.latch && i_cmd.exec))
        else $error("latch and exec together");

endmodule

// File: hdl/trie_ctrl.sv
// ----------------------------------------------------------------------------
// trie_ctrl
// Sequencer: handshakes, operand read, divide iterations, result hold.
// ----------------------------------------------------------------------------
module trie_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output trie_pkg::t_cmd  o_cmd,
    input  trie_pkg::t_sts  i_sts
);
    import trie_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       in_acc;

    // a new item may enter while the previous result waits
    assign o_in_stall  = r_state != S_IDLE;
    assign in_acc      = i_in_valid && r_state == S_IDLE;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid && i_out_stall;
        o_cmd     = '0;
        o_cmd.latch = in_acc;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_DEC;
            S_DEC: begin
                if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!n_ovalid) begin
                    o_cmd.exec = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_ovalid)
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_out_stall |-> !o_cmd.exec)
        else $error("result overwritten");

endmodule

// File: hdl/three_register_instruction_execute.sv
// ----------------------------------------------------------------------------
// three_register_instruction_execute
// Executes one instruction word or request response per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | op, instr_word, resp_data, resp_eof
//  output  | out       | o_out_valid / i_out_stall  | req_kind, req_a..c, next_pc, waiting
//
// Divide by a nonzero divisor runs 32 restoring steps between accept and result;
// all other items skip the divider. One item in flight; the result register lets the
// next item enter while a result waits. Synchronous active-low reset clears
// registers, PC and flags.
module three_register_instruction_execute #(
    parameter int unsigned REG_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_resp_data,
    input  logic        i_resp_eof,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_req_kind,
    output logic [31:0] o_req_a,
    output logic [31:0] o_req_b,
    output logic [31:0] o_req_c,
    output logic [31:0] o_next_pc,
    output logic        o_waiting
);
    import trie_pkg::*;

    t_cmd cmd;
    t_sts sts;

    trie_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .o_cmd(cmd), .i_sts(sts)
    );

    trie_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_op, .i_instr_word, .i_resp_data, .i_resp_eof,
        .o_req_kind, .o_req_a, .o_req_b, .o_req_c, .o_next_pc, .o_waiting
    );

endmodule

// File: dv/trie_checker.sv
// ----------------------------------------------------------------------------
// trie_checker
// Watches both channels of the instruction execute block, predicts each
// result from its own copy of the register file and flags, and compares.
// ----------------------------------------------------------------------------
module trie_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_resp_data,
    input  logic        i_resp_eof,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_req_kind,
    input  logic [31:0] i_req_a,
    input  logic [31:0] i_req_b,
    input  logic [31:0] i_req_c,
    input  logic [31:0] i_next_pc,
    input  logic        i_waiting,
    output int          o_fail_count,
    output int          o_pending_count,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import trie_pkg::*;

    typedef struct packed {
        t_kind kind;
        t_word qa;
        t_word qb;
        t_word qc;
        t_word pc;
        logic  waiting;
    } t_request;

    t_word    regs [8];
    t_word    pc;
    t_ridx    wait_dest;
    logic     wait_flag;
    logic     halt_flag;
    t_request expected_requests [$];

    assign o_pending_count = expected_requests.size();

    function automatic t_request execute_item(logic op, t_word w, t_word data, logic eof);
        t_request r;
        logic [3:0] opc;
        t_ridx ra, rb, rc;
        r = '0;
        opc = w[31:28];
        ra = w[8:6];
        rb = w[5:3];
        rc = w[2:0];
        if (halt_flag) begin
            r.kind = K_HALT;
        end else if (op) begin
            if (wait_flag) begin
                regs[wait_dest] = eof ? '1 : data;
                wait_flag = 1'b0;
            end
        end else if (!wait_flag) begin
            pc = pc + 1;
            case (opc)
                OP_CMOV: if (regs[rc] != 0) regs[ra] = regs[rb];
                OP_LOAD: begin
                    r.kind = K_LOAD; r.qa = regs[rb]; r.qb = regs[rc];
                    wait_dest = ra; wait_flag = 1'b1;
                end
                OP_STORE: begin
                    r.kind = K_STORE; r.qa = regs[ra]; r.qb = regs[rb]; r.qc = regs[rc];
                end
                OP_ADD: regs[ra] = regs[rb] + regs[rc];
                OP_MUL: regs[ra] = regs[rb] * regs[rc];
                OP_DIV: begin
                    if (regs[rc] == 0) r.kind = K_DIVERR;
                    else regs[ra] = regs[rb] / regs[rc];
                end
                OP_NAND: regs[ra] = ~(regs[rb] & regs[rc]);
                OP_HALT: begin
                    r.kind = K_HALT; halt_flag = 1'b1;
                end
                OP_MAP: begin
                    r.kind = K_MAP; r.qa = regs[rc];
                    wait_dest = rb; wait_flag = 1'b1;
                end
                OP_UNMAP: begin
                    r.kind = K_UNMAP; r.qa = regs[rc];
                end
                OP_OUT: begin
                    r.kind = K_OUT; r.qa = {24'd0, regs[rc][7:0]};
                end
                OP_IN: begin
                    r.kind = K_IN; wait_dest = rc; wait_flag = 1'b1;
                end
                OP_LOADP: begin
                    if (regs[rb] != 0) begin
                        r.kind = K_LOADP; r.qa = regs[rb];
                    end
                    pc = regs[rc];
                end
                OP_IMM: regs[w[27:25]] = {7'd0, w[24:0]};
                default: ;
            endcase
        end
        r.pc = pc;
        r.waiting = wait_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_request exp_r;
        if (!i_rst_n) begin
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            wait_dest = '0;
            wait_flag = 1'b0;
            halt_flag = 1'b0;
            expected_requests.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (expected_requests.size() == 0) begin
                    $error("unexpected result transaction, kind %0d", i_req_kind);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_requests.pop_front();
                    if ({i_req_kind, i_req_a, i_req_b, i_req_c, i_next_pc, i_waiting}
                            !== exp_r) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_req_kind !== exp_r.kind)
                            $error("req_kind exp %0d got %0d", exp_r.kind, i_req_kind);
                        if (i_req_a !== exp_r.qa)
                            $error("req_a exp %h got %h", exp_r.qa, i_req_a);
                        if (i_req_b !== exp_r.qb)
                            $error("req_b exp %h got %h", exp_r.qb, i_req_b);
                        if (i_req_c !== exp_r.qc)
                            $error("req_c exp %h got %h", exp_r.qc, i_req_c);
                        if (i_next_pc !== exp_r.pc)
                            $error("next_pc exp %h got %h", exp_r.pc, i_next_pc);
                        if (i_waiting !== exp_r.waiting)
                            $error("waiting exp %b got %b", exp_r.waiting, i_waiting);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_requests.push_back(
                    execute_item(i_op, i_instr_word, i_resp_data, i_resp_eof));
        end
    end
endmodule

// File: dv/tb_three_register_instruction_execute.sv
// ----------------------------------------------------------------------------
// tb_three_register_instruction_execute
// Drives instruction and response transactions into the execute block with
// random idling and a long output hold-off; a checker predicts the results.
// ----------------------------------------------------------------------------
module tb_three_register_instruction_execute;
    timeunit 1ns;
    timeprecision 1ps;
    import trie_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = 1'b0;
    logic [31:0] i_instr_word = '0;
    logic [31:0] i_resp_data = '0;
    logic        i_resp_eof = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_req_kind;
    logic [31:0] o_req_a, o_req_b, o_req_c, o_next_pc;
    logic        o_waiting;

    int fail_count, pending_count, result_count;
    int send_idle_pct = 30;
    int recv_idle_pct = 82;
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    int sent_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    three_register_instruction_execute uut (.*);

    trie_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_op, .i_instr_word,
        .i_resp_data, .i_resp_eof, .i_out_valid(o_out_valid), .i_out_stall,
        .i_req_kind(o_req_kind), .i_req_a(o_req_a), .i_req_b(o_req_b),
        .i_req_c(o_req_c), .i_next_pc(o_next_pc), .i_waiting(o_waiting),
        .o_fail_count(fail_count), .o_pending_count(pending_count),
        .o_result_count(result_count)
    );

    // receiver side stalls
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL three_register_instruction_execute");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [31:0] w, logic [31:0] data, logic eof);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_instr_word <= w;
        i_resp_data <= data;
        i_resp_eof <= eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [31:0] make_instr(logic [3:0] opc);
        logic [31:0] w;
        w = $urandom();
        w[31:28] = opc;
        // mostly keep divisors nonzero-ish by leaving register bits random
        return w;
    endfunction

    // full random program chunk: instructions, answered when a response is due
    task automatic random_run(int n);
        logic [3:0] opc;
        logic [31:0] w;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                // noise: unsolicited response or instruction while waiting
                do w = $urandom(); while (w[31:28] == OP_HALT);
                send_item($urandom_range(1), w, $urandom(), $urandom_range(1));
            end else begin
                do opc = $urandom_range(15); while (opc == OP_HALT);
                w = make_instr(opc);
                if (opc == OP_IMM && $urandom_range(1)) w[24:0] = '1;
                send_item(1'b0, w, $urandom(), 1'b0);
                if (opc == OP_LOAD || opc == OP_MAP || opc == OP_IN) begin
                    if ($urandom_range(9) == 0)
                        send_item(1'b0, $urandom(), $urandom(), 1'b0);
                    send_item(1'b1, $urandom(), $urandom(), $urandom_range(7) == 0);
                end
            end
        end
    endtask

    task automatic reset_machine_halt();
        // halt, then a few ignored items
        send_item(1'b0, {OP_HALT, 28'd0}, '0, 1'b0);
        repeat (3) send_item($urandom_range(1), $urandom(), $urandom(), $urandom_range(1));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: immediates at the extremes, every opcode but halt
        send_item(1'b0, {OP_IMM, 3'd1, 25'h1FFFFFF}, '0, 1'b0);
        send_item(1'b0, {OP_IMM, 3'd2, 25'd0}, '0, 1'b0);
        send_item(1'b0, {OP_IMM, 3'd3, 25'd7}, '0, 1'b0);
        send_item(1'b0, {OP_DIV, 19'd0, 3'd4, 3'd1, 3'd2}, '0, 1'b0); // divide by zero
        send_item(1'b0, {OP_DIV, 19'd0, 3'd4, 3'd1, 3'd3}, '0, 1'b0);
        send_item(1'b0, {OP_NAND, 19'd0, 3'd5, 3'd2, 3'd2}, '0, 1'b0); // all ones
        send_item(1'b0, {OP_DIV, 19'd0, 3'd6, 3'd5, 3'd3}, '0, 1'b0);
        send_item(1'b0, {OP_MUL, 19'd0, 3'd6, 3'd5, 3'd5}, '0, 1'b0);
        send_item(1'b0, {OP_ADD, 19'd0, 3'd7, 3'd5, 3'd1}, '0, 1'b0);
        send_item(1'b0, {OP_CMOV, 19'd0, 3'd0, 3'd5, 3'd2}, '0, 1'b0);
        send_item(1'b0, {OP_CMOV, 19'd0, 3'd0, 3'd5, 3'd3}, '0, 1'b0);
        send_item(1'b0, {OP_STORE, 19'd0, 3'd1, 3'd3, 3'd5}, '0, 1'b0);
        send_item(1'b0, {OP_LOAD, 19'd0, 3'd2, 3'd1, 3'd3}, '0, 1'b0);
        send_item(1'b0, {OP_ADD, 28'd0}, '0, 1'b0); // ignored while waiting
        send_item(1'b1, '0, 32'hFFFF_FFFF, 1'b0);
        send_item(1'b1, '0, 32'h1234_5678, 1'b0);  // nothing pending
        send_item(1'b0, {OP_MAP, 19'd0, 3'd0, 3'd4, 3'd5}, '0, 1'b0);
        send_item(1'b1, '0, 32'h0, 1'b0);
        send_item(1'b0, {OP_IN, 19'd0, 3'd0, 3'd0, 3'd6}, '0, 1'b0);
        send_item(1'b1, '0, 32'h0, 1'b1);           // end of file
        send_item(1'b0, {OP_UNMAP, 19'd0, 3'd0, 3'd0, 3'd5}, '0, 1'b0);
        send_item(1'b0, {OP_OUT, 19'd0, 3'd0, 3'd0, 3'd5}, '0, 1'b0);
        send_item(1'b0, {OP_LOADP, 19'd0, 3'd0, 3'd2, 3'd3}, '0, 1'b0); // nonzero segment
        send_item(1'b0, {OP_LOADP, 19'd0, 3'd0, 3'd5, 3'd1}, '0, 1'b0);
        send_item(1'b0, {4'd14, 28'hFFFFFFF}, '0, 1'b0);
        send_item(1'b0, {4'd15, 28'd0}, '0, 1'b0);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_run(20);
        join

        random_run(480);
        send_idle_pct = 82;
        recv_idle_pct = 30;
        random_run(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(480);
        reset_machine_halt();
        drain();

        $display("covered %0d input transactions and %0d results over all opcodes,",
                 sent_count, result_count);
        $display("responses with end of file, divide errors, and halt lockup");
        if (fail_count == 0) begin
            $display("PASS three_register_instruction_execute");
        end else begin
            $display("FAIL three_register_instruction_execute");
        end
        $finish;
    end
endmodule
